### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Holds the fixed datapath widths, the status codes and the sideband words
// that travel beside the square root and divider cell rows.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Coefficient width, signed Q16.16
    localparam int COEF_W = 32;
    // Output root width, signed Q32.16, and the miss distance width
    localparam int ROOT_W = 48;
    localparam int MISS_W = 47;

    // Discriminant, square root remainder and root widths
    localparam int SQ_DW    = 66;
    localparam int SQ_RW    = 35;
    localparam int SQ_QW    = 33;
    localparam int SQ_STEPS = 33;

    // Divisor 2|a| and numerator magnitude |-b +/- sqrt(D)|
    localparam int DEN_W = 33;
    localparam int MAG_W = 34;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_TWO    = 2'd2,
        ST_AZERO  = 2'd3
    } t_status;

    // Sideband beside the square root row
    typedef struct packed {
        logic                     vld;
        t_status                  status;
        logic signed [COEF_W-1:0] b;
        logic                     a_neg;
        logic [DEN_W-1:0]         den;
    } t_sq_side;

    // Sideband beside the divider rows
    typedef struct packed {
        logic             vld;
        t_status          status;
        logic [DEN_W-1:0] den;
        logic             neg_p;
        logic             neg_m;
    } t_dv_side;

endpackage

### rtl/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: real roots of a x^2 + b x + c in fixed point
// Coefficient words in, root pair and status out, fully pipelined.
// ----------------------------------------------------------------------------
// One coefficient word is taken every clock cycle while the output does not
// stall, and each word passes through the input register, multiply,
// discriminant, a row of 33 square root cells, numerator stage, two parallel
// rows of 34 + FRAC_BITS divider cells and the output register.
// The whole pipeline holds while a result waits at the output and is not
// taken. Roots are truncated toward zero and saturated to signed Q32.16; a
// zero a or a negative discriminant returns the miss distance in both roots.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Coefficients
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // coef_a[31:0], coef_b[63:32], coef_c[95:64]
    // Roots
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // root_plus[47:0], root_minus[95:48]
    output logic [1:0]   o_m_axis_tuser,   // root_status[1:0]
    // Miss distance register
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [46:0]  i_cfg_data
);

    localparam int DW = MAG_W + FRAC_BITS;
    localparam int XW = DW + ROOT_W;
    localparam logic [MISS_W-1:0] MISS_RST = MISS_W'(64'd100000 << FRAC_BITS);
    localparam logic [XW-1:0] NEG_LIM = XW'(1) << (ROOT_W-1);

    logic                     w_adv;
    logic [MISS_W-1:0]        r_miss;

    logic                     r_v0;
    logic signed [COEF_W-1:0] r_a, r_b, r_c;

    logic [COEF_W-1:0]        w_mag_a, w_mag_b, w_mag_c;
    logic [2*COEF_W-1:0]      r_b2, r_p;
    logic                     r_acpos;
    t_sq_side                 r_s1_side;

    logic [SQ_DW-1:0]         w_q4, w_b2x, w_sum, w_dif;
    logic [SQ_DW-1:0]         r_d;

    logic [SQ_DW-1:0]         w_sq_d    [0:SQ_STEPS];
    logic [SQ_RW-1:0]         w_sq_rem  [0:SQ_STEPS];
    logic [SQ_QW-1:0]         w_sq_root [0:SQ_STEPS];
    t_sq_side                 r_sq_side [0:SQ_STEPS];

    logic signed [SQ_QW+1:0]  w_nb, w_sx, w_num_p, w_num_m;
    logic [MAG_W-1:0]         w_mag_p, w_mag_m;
    logic [DW-1:0]            r_dp_num, r_dm_num;

    logic [DW-1:0]            w_dp_num [0:DW];
    logic [DEN_W-1:0]         w_dp_rem [0:DW];
    logic [DW-1:0]            w_dp_quo [0:DW];
    logic [DW-1:0]            w_dm_num [0:DW];
    logic [DEN_W-1:0]         w_dm_rem [0:DW];
    logic [DW-1:0]            w_dm_quo [0:DW];
    t_dv_side                 r_dv_side [0:DW];

    logic [XW-1:0]            w_qp, w_qm;
    logic [ROOT_W-1:0]        w_root_p, w_root_m, w_miss_x;
    logic                     r_out_vld;
    logic [ROOT_W-1:0]        r_out_p, r_out_m;
    t_status                  r_out_st;

    // Advance the whole pipe unless a result is held at the output
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;

    // Hold the miss distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= MISS_RST;
        end else if (i_cfg_valid) begin
            r_miss <= i_cfg_data;
        end
    end

    // Register the coefficient word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a <= i_s_axis_tdata[31:0];
            r_b <= i_s_axis_tdata[63:32];
            r_c <= i_s_axis_tdata[95:64];
        end
    end

    // Form b^2 and |a c|
    assign w_mag_a = r_a[COEF_W-1] ? COEF_W'(-r_a) : COEF_W'(r_a);
    assign w_mag_b = r_b[COEF_W-1] ? COEF_W'(-r_b) : COEF_W'(r_b);
    assign w_mag_c = r_c[COEF_W-1] ? COEF_W'(-r_c) : COEF_W'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_side.vld <= r_v0;
        end
        if (w_adv) begin
            r_b2             <= w_mag_b * w_mag_b;
            r_p              <= w_mag_a * w_mag_c;
            r_acpos          <= (r_c != '0) && (r_a[COEF_W-1] == r_c[COEF_W-1]);
            r_s1_side.status <= (r_a == '0) ? ST_AZERO : ST_TWO;
            r_s1_side.b      <= r_b;
            r_s1_side.a_neg  <= r_a[COEF_W-1];
            r_s1_side.den    <= {w_mag_a, 1'b0};
        end
    end

    // Form the discriminant and classify it
    assign w_q4  = {r_p, 2'b00};
    assign w_b2x = SQ_DW'(r_b2);
    assign w_sum = w_b2x + w_q4;
    assign w_dif = w_b2x - w_q4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_side[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_sq_side[0].vld <= r_s1_side.vld;
        end
        if (w_adv) begin
            r_sq_side[0].b     <= r_s1_side.b;
            r_sq_side[0].a_neg <= r_s1_side.a_neg;
            r_sq_side[0].den   <= r_s1_side.den;
            if (r_s1_side.status == ST_AZERO) begin
                r_sq_side[0].status <= ST_AZERO;
                r_d                 <= '0;
            end else if (!r_acpos) begin
                r_sq_side[0].status <= (w_sum == '0) ? ST_DOUBLE : ST_TWO;
                r_d                 <= w_sum;
            end else if (w_q4 > w_b2x) begin
                r_sq_side[0].status <= ST_NONE;
                r_d                 <= '0;
            end else begin
                r_sq_side[0].status <= (w_dif == '0) ? ST_DOUBLE : ST_TWO;
                r_d                 <= w_dif;
            end
        end
    end

    // Square root row
    assign w_sq_d[0]    = r_d;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_d    (w_sq_d[k]),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .o_d    (w_sq_d[k+1]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_side[k+1].vld <= 1'b0;
            end else if (w_adv) begin
                r_sq_side[k+1].vld <= r_sq_side[k].vld;
            end
            if (w_adv) begin
                r_sq_side[k+1].status <= r_sq_side[k].status;
                r_sq_side[k+1].b      <= r_sq_side[k].b;
                r_sq_side[k+1].a_neg  <= r_sq_side[k].a_neg;
                r_sq_side[k+1].den    <= r_sq_side[k].den;
            end
        end
    end

    // Form -b +/- sqrt(D), its magnitude and the quotient sign
    assign w_nb    = -{{3{r_sq_side[SQ_STEPS].b[COEF_W-1]}}, r_sq_side[SQ_STEPS].b};
    assign w_sx    = {2'b00, w_sq_root[SQ_STEPS]};
    assign w_num_p = w_nb + w_sx;
    assign w_num_m = w_nb - w_sx;
    assign w_mag_p = w_num_p[SQ_QW+1] ? MAG_W'(-w_num_p) : MAG_W'(w_num_p);
    assign w_mag_m = w_num_m[SQ_QW+1] ? MAG_W'(-w_num_m) : MAG_W'(w_num_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_side[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_dv_side[0].vld <= r_sq_side[SQ_STEPS].vld;
        end
        if (w_adv) begin
            r_dv_side[0].status <= r_sq_side[SQ_STEPS].status;
            r_dv_side[0].den    <= r_sq_side[SQ_STEPS].den;
            r_dv_side[0].neg_p  <= (w_num_p[SQ_QW+1] != r_sq_side[SQ_STEPS].a_neg)
                                   && (w_num_p != '0);
            r_dv_side[0].neg_m  <= (w_num_m[SQ_QW+1] != r_sq_side[SQ_STEPS].a_neg)
                                   && (w_num_m != '0);
            r_dp_num            <= {w_mag_p, FRAC_BITS'(0)};
            r_dm_num            <= {w_mag_m, FRAC_BITS'(0)};
        end
    end

    // Divider rows, one per root
    assign w_dp_num[0] = r_dp_num;
    assign w_dm_num[0] = r_dm_num;
    assign w_dp_rem[0] = '0;
    assign w_dp_quo[0] = '0;
    assign w_dm_rem[0] = '0;
    assign w_dm_quo[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_dv
        qrs_div_cell #(
            .NUM_W (DW)
        ) u_plus (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (w_dp_num[k]),
            .i_rem (w_dp_rem[k]),
            .i_quo (w_dp_quo[k]),
            .i_den (r_dv_side[k].den),
            .o_num (w_dp_num[k+1]),
            .o_rem (w_dp_rem[k+1]),
            .o_quo (w_dp_quo[k+1])
        );

        qrs_div_cell #(
            .NUM_W (DW)
        ) u_minus (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (w_dm_num[k]),
            .i_rem (w_dm_rem[k]),
            .i_quo (w_dm_quo[k]),
            .i_den (r_dv_side[k].den),
            .o_num (w_dm_num[k+1]),
            .o_rem (w_dm_rem[k+1]),
            .o_quo (w_dm_quo[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[k+1].vld <= 1'b0;
            end else if (w_adv) begin
                r_dv_side[k+1].vld <= r_dv_side[k].vld;
            end
            if (w_adv) begin
                r_dv_side[k+1].status <= r_dv_side[k].status;
                r_dv_side[k+1].den    <= r_dv_side[k].den;
                r_dv_side[k+1].neg_p  <= r_dv_side[k].neg_p;
                r_dv_side[k+1].neg_m  <= r_dv_side[k].neg_m;
            end
        end
    end

    // Saturate and apply the sign
    assign w_qp = XW'(w_dp_quo[DW]);
    assign w_qm = XW'(w_dm_quo[DW]);

    always_comb begin
        if (!r_dv_side[DW].neg_p) begin
            w_root_p = (|w_qp[XW-1:ROOT_W-1]) ? {1'b0, {(ROOT_W-1){1'b1}}}
                                             : w_qp[ROOT_W-1:0];
        end else begin
            w_root_p = (w_qp > NEG_LIM) ? {1'b1, {(ROOT_W-1){1'b0}}}
                                       : ROOT_W'(-w_qp[ROOT_W-1:0]);
        end
        if (!r_dv_side[DW].neg_m) begin
            w_root_m = (|w_qm[XW-1:ROOT_W-1]) ? {1'b0, {(ROOT_W-1){1'b1}}}
                                             : w_qm[ROOT_W-1:0];
        end else begin
            w_root_m = (w_qm > NEG_LIM) ? {1'b1, {(ROOT_W-1){1'b0}}}
                                       : ROOT_W'(-w_qm[ROOT_W-1:0]);
        end
    end

    assign w_miss_x = {1'b0, r_miss};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_dv_side[DW].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_st <= r_dv_side[DW].status;
            case (r_dv_side[DW].status) inside
                ST_NONE, ST_AZERO: begin
                    r_out_p <= w_miss_x;
                    r_out_m <= w_miss_x;
                end
                default: begin
                    r_out_p <= w_root_p;
                    r_out_m <= w_root_m;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_m, r_out_p};
    assign o_m_axis_tuser  = r_out_st;

endmodule

### rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit step of the integer square root
// Takes the next bit pair of the radicand, tries the subtraction and hands
// radicand, remainder and partial root on to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
    import qrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SQ_DW-1:0] i_d,
    input  logic [SQ_RW-1:0] i_rem,
    input  logic [SQ_QW-1:0] i_root,
    output logic [SQ_DW-1:0] o_d,
    output logic [SQ_RW-1:0] o_rem,
    output logic [SQ_QW-1:0] o_root
);

    logic [SQ_RW+1:0] w_rem;
    logic [SQ_RW+1:0] w_trial;
    logic             w_ge;

    // Bring down the next pair and compare against 4*root+1
    assign w_rem   = {i_rem, i_d[SQ_DW-1 -: 2]};
    assign w_trial = (SQ_RW+2)'({i_root, 2'b01});
    assign w_ge    = (w_rem >= w_trial);

    // Advance one digit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d    <= {i_d[SQ_DW-3:0], 2'b00};
            o_rem  <= w_ge ? SQ_RW'(w_rem - w_trial) : SQ_RW'(w_rem);
            o_root <= {i_root[SQ_QW-2:0], w_ge};
        end
    end

endmodule

### rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one bit step of restoring division
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor where it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module qrs_div_cell
    import qrs_pkg::*;
#(
    parameter int NUM_W = 50
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_quo,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_num,
    output logic [DEN_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W:0] w_trial;
    logic           w_ge;

    // Try the subtraction on the extended remainder
    assign w_trial = {i_rem, i_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});

    // Advance one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[NUM_W-2:0], 1'b0};
            o_rem <= w_ge ? DEN_W'(w_trial - {1'b0, i_den}) : DEN_W'(w_trial);
            o_quo <= {i_quo[NUM_W-2:0], w_ge};
        end
    end

endmodule

### sim/tb_quadratic_root_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_core: self-checking bench of the root solver
// Drives coefficient words with random gaps, stalls the root stream at random
// and compares every root word with a typed expectation or a bit-true solver
// predictor. The miss distance is rewritten between phases on an empty pipe.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_core
    import qrs_pkg::*;
();

    localparam int FRAC = 16;
    localparam logic [47:0] DEF_MISS = 48'd6553600000;
    localparam logic [47:0] POS_SAT = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_SAT = 48'h8000_0000_0000;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [47:0] plus;
        logic [47:0] minus;
        t_status     status;
    } t_roots;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic        typed;
        t_roots      roots;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [46:0] cfg_data = '0;

    logic [46:0] miss_reg = DEF_MISS[46:0];
    t_row        sent_q[$];
    t_roots      roots_q[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;
    int          stall_left = 0;

    quadratic_root_solver_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // coef_a[31:0], coef_b[63:32], coef_c[95:64]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // root_plus[47:0], root_minus[95:48]
        .o_m_axis_tuser  (m_tuser),   // root_status[1:0]
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Quotient (num << FRAC) / 2|a|, truncated toward zero, saturated
    function automatic logic [47:0] root_quot(logic signed [79:0] num,
                                              logic signed [79:0] a);
        logic [79:0] mag_n;
        logic [79:0] mag_a;
        logic [79:0] q;
        bit          neg;
        neg   = (num < 0) != (a < 0);
        if (num == 0) neg = 1'b0;
        mag_n = (num < 0) ? -num : num;
        mag_a = (a < 0) ? -a : a;
        q     = (mag_n << FRAC) / (mag_a << 1);
        if (!neg) begin
            if (q > {32'd0, POS_SAT}) return POS_SAT;
            return q[47:0];
        end
        if (q > {32'd0, NEG_SAT}) return NEG_SAT;
        q = -q;
        return q[47:0];
    endfunction

    // Floor of the square root of the discriminant
    function automatic logic [79:0] floor_sqrt(logic [79:0] d);
        logic [79:0] r;
        logic [79:0] t;
        r = '0;
        for (int i = 34; i >= 0; i--) begin
            t = r | (80'd1 << i);
            if (t * t <= d) r = t;
        end
        return r;
    endfunction

    // Both real roots and status of one coefficient word
    function automatic t_roots solve_roots(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [46:0] miss);
        logic signed [79:0] av;
        logic signed [79:0] bv;
        logic signed [79:0] cv;
        logic signed [79:0] disc;
        logic signed [79:0] s;
        t_roots             r;
        av = {{48{a[31]}}, a};
        bv = {{48{b[31]}}, b};
        cv = {{48{c[31]}}, c};
        r.plus  = {1'b0, miss};
        r.minus = {1'b0, miss};
        if (av == 0) begin
            r.status = ST_AZERO;
            return r;
        end
        disc = bv * bv - 4 * av * cv;
        if (disc < 0) begin
            r.status = ST_NONE;
        end else if (disc == 0) begin
            r.plus   = root_quot(-bv, av);
            r.minus  = r.plus;
            r.status = ST_DOUBLE;
        end else begin
            s        = floor_sqrt(disc);
            r.plus   = root_quot(-bv + s, av);
            r.minus  = root_quot(-bv - s, av);
            r.status = ST_TWO;
        end
        return r;
    endfunction

    // Random coefficient word, weighted toward the interesting cases
    function automatic t_row rand_word();
        t_row        w;
        int          k;
        logic [31:0] m;
        logic [31:0] n;
        logic [31:0] edges[5];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF};
        w = '0;
        k = $urandom_range(0, 9);
        w.a = $urandom;
        w.b = $urandom;
        w.c = $urandom;
        case (k)
            0: begin
                w.a = '0;
            end
            1: begin
                // double root: a = m, b = 2mn, c = mn^2
                m = $urandom_range(1, 2000);
                n = $urandom_range(0, 300);
                if ($urandom_range(0, 1)) m = -m;
                if ($urandom_range(0, 1)) n = -n;
                w.a = m;
                w.b = 2 * m * n;
                w.c = m * n * n;
            end
            2, 3: begin
                w.a = $signed(w.a) >>> $urandom_range(10, 28);
                w.b = $signed(w.b) >>> $urandom_range(8, 28);
                w.c = $signed(w.c) >>> $urandom_range(8, 28);
                if (w.a == 0) w.a = 32'd65536;
            end
            4: begin
                w.a = edges[$urandom_range(0, 4)];
                w.b = edges[$urandom_range(0, 4)];
                w.c = edges[$urandom_range(0, 4)];
            end
            default: ;
        endcase
        return w;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one coefficient word and hold it until taken
    task automatic send_word(t_row w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sent_q.push_back(w);
        s_tvalid <= 1'b1;
        s_tdata  <= {w.c, w.b, w.a};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drain the pipe, then rewrite the miss distance
    task automatic write_miss(logic [46:0] value);
        s_tvalid <= 1'b0;
        while (roots_q.size() != 0 || sent_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result stall pattern
    always @(posedge i_clk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Track accepted words, predict and check the root words
    always @(posedge i_clk) begin
        t_row   w;
        t_roots got;
        t_roots want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                w = sent_q.pop_front();
                roots_q.push_back(w.typed ? w.roots : solve_roots(w.a, w.b, w.c, miss_reg));
            end
            if (cfg_valid && cfg_ready) miss_reg <= cfg_data;
            if (m_tvalid && m_tready) begin
                got.plus   = m_tdata[47:0];
                got.minus  = m_tdata[95:48];
                got.status = t_status'(m_tuser);
                if (roots_q.size() == 0) begin
                    $display("%0t: root word with none expected: %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = roots_q.pop_front();
                    if (got.plus !== want.plus) begin
                        $display("%0t: root_plus exp %h got %h", $time, want.plus, got.plus);
                        failed = 1'b1;
                    end
                    if (got.minus !== want.minus) begin
                        $display("%0t: root_minus exp %h got %h", $time,
                                 want.minus, got.minus);
                        failed = 1'b1;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: root_status exp %0d got %0d", $time,
                                 want.status, got.status);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_quadratic_root_solver_core: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row        rows[$];
        logic [46:0] miss_vals[4];
        t_row        w;
        miss_vals = '{47'd0, 47'h7FFF_FFFF_FFFF, 47'd0, 47'd65536};
        miss_vals[2] = 47'({$urandom, $urandom});

        // Directed words; typed expectations only where obvious
        w = '0; w.typed = 1'b1;
        w.a = 0; w.b = 32'h7FFF_FFFF; w.c = 32'h8000_0000;
        w.roots = '{DEF_MISS, DEF_MISS, ST_AZERO};
        rows.push_back(w);
        w.a = 32'd65536; w.b = 0; w.c = 32'd65536;
        w.roots = '{DEF_MISS, DEF_MISS, ST_NONE};
        rows.push_back(w);
        w.a = 32'd65536; w.b = -32'sd131072; w.c = 32'd65536;
        w.roots = '{48'd65536, 48'd65536, ST_DOUBLE};
        rows.push_back(w);
        w.a = 32'd65536; w.b = 0; w.c = -32'sd262144;
        w.roots = '{48'd131072, -48'sd131072, ST_TWO};
        rows.push_back(w);
        w.a = 32'd1; w.b = 32'h8000_0000; w.c = 0;
        w.roots = '{POS_SAT, 48'd0, ST_TWO};
        rows.push_back(w);
        w.typed = 1'b0;
        w.a = 32'hFFFF_FFFF; w.b = 32'h8000_0000; w.c = 0;           rows.push_back(w);
        w.a = 32'h8000_0000; w.b = 32'h8000_0000; w.c = 32'h7FFF_FFFF; rows.push_back(w);
        w.a = 32'h7FFF_FFFF; w.b = 32'h7FFF_FFFF; w.c = 32'h8000_0000; rows.push_back(w);
        w.a = 32'h7FFF_FFFF; w.b = 32'h8000_0000; w.c = 32'h7FFF_FFFF; rows.push_back(w);
        w.a = 32'h8000_0000; w.b = 0; w.c = 32'h8000_0000;           rows.push_back(w);
        w.a = 32'd1; w.b = 32'd3; w.c = 32'd2;                        rows.push_back(w);
        w.a = 32'd1; w.b = 32'd1; w.c = 0;                            rows.push_back(w);
        w.a = -32'sd65536; w.b = 32'd65536; w.c = 32'd131072;         rows.push_back(w);
        w.a = 32'd2; w.b = 32'h7FFF_FFFF; w.c = 32'h7FFF_FFFF;        rows.push_back(w);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words, then random words, at the reset miss distance
        foreach (rows[i]) send_word(rows[i]);
        for (int n = 0; n < 150; n++) send_word(rand_word());

        // Random phases over several miss distances, one without idling
        for (int ph = 0; ph < 4; ph++) begin
            write_miss(miss_vals[ph]);
            quiet = (ph == 2);
            for (int n = 0; n < 240; n++) send_word(rand_word());
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (roots_q.size() != 0 || sent_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (!failed) begin
            $display("tb_quadratic_root_solver_core: PASS");
        end else begin
            $display("tb_quadratic_root_solver_core: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_core.sv
sim/tb_quadratic_root_solver_core.sv
